### hw/rtl/sensor_average_threshold_control_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sensor averaging block.
// ----------------------------------------------------------------------------
`ifndef SENSOR_AVERAGE_THRESHOLD_CONTROL_MACROS_SVH
`define SENSOR_AVERAGE_THRESHOLD_CONTROL_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SAT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define SAT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Register map, widths and reset values for the sensor averaging block.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int unsigned SetpointW = 12;
  localparam int unsigned MeanW     = 12;
  localparam int unsigned CountW    = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef logic [SetpointW-1:0] setpoint_t;
  typedef logic [CountW-1:0]    count_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOISTURE_SETPOINT    = 3'd0,
    REG_TEMPERATURE_SETPOINT = 3'd1,
    REG_LIGHT_THRESHOLD      = 3'd2,
    REG_PHOTOPERIOD_ENABLE   = 3'd3,
    REG_LIGHT_GOAL_SECONDS   = 3'd4
  } cfg_reg_e;

  localparam setpoint_t MoistureSetpointRst    = setpoint_t'(3000);
  localparam setpoint_t TemperatureSetpointRst = setpoint_t'(1600);
  localparam setpoint_t LightThresholdRst      = setpoint_t'(2000);
  localparam logic      PhotoperiodEnableRst   = 1'b0;
  localparam count_t    LightGoalSecondsRst    = count_t'(14 * 3600);

  // Drive bits produced for each item.
  typedef struct packed {
    logic pump;
    logic fan;
    logic grow;
  } drive_t;

endpackage

### hw/rtl/sat_channel.sv
// ----------------------------------------------------------------------------
// sat_channel
// One sensor channel: circular sample history, running sum and mean.
// ----------------------------------------------------------------------------
module sat_channel #(
  parameter int unsigned AVERAGE_SHIFT = 5,
  parameter int unsigned SAMPLE_BITS   = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     update_i,
  input  logic [AVERAGE_SHIFT-1:0] slot_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic [SAMPLE_BITS-1:0]   mean_o
);

  localparam int unsigned Depth = 1 << AVERAGE_SHIFT;
  localparam int unsigned SumW  = SAMPLE_BITS + AVERAGE_SHIFT;

  logic [SAMPLE_BITS-1:0] hist_q [Depth];
  logic [SumW-1:0]        sum_q, sum_d;

  // oldest sample drops out, new one comes in
  assign sum_d  = sum_q - SumW'(hist_q[slot_i]) + SumW'(sample_i);
  assign mean_o = sum_d[SumW-1:AVERAGE_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        hist_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (update_i) begin
      hist_q[slot_i] <= sample_i;
      sum_q          <= sum_d;
    end
  end

endmodule

### hw/rtl/sensor_average_threshold_control.sv
// ----------------------------------------------------------------------------
// sensor_average_threshold_control
// Running-mean filters on three sensor channels, lit-seconds counting and
// pump / fan / grow-light drive decisions.
// ----------------------------------------------------------------------------
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    light, temperature, moisture samples, clear
// out      out_valid_o / out_ready_i  three means, drive bits, lit seconds
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i (always ready)
//
// One item per cycle sustained while out_ready_i is held; an accepted input
// passes through the input register, then the result register.
// The history read, sum update and threshold compares sit between the two.
// Reset clears histories, sums, counters and loads register defaults at once.
// A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
`include "sensor_average_threshold_control_macros.svh"

module sensor_average_threshold_control
  import sat_pkg::*;
#(
  parameter int unsigned AVERAGE_SHIFT    = 5,
  parameter int unsigned TICKS_PER_SECOND = 10,
  parameter int unsigned SAMPLE_BITS      = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] light_sample_i,
  input  logic [SAMPLE_BITS-1:0] temperature_sample_i,
  input  logic [SAMPLE_BITS-1:0] moisture_sample_i,
  input  logic                   clear_light_count_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [MeanW-1:0]       light_mean_o,
  output logic [MeanW-1:0]       temperature_mean_o,
  output logic [MeanW-1:0]       moisture_mean_o,
  output logic                   pump_on_o,
  output logic                   fan_on_o,
  output logic                   grow_light_on_o,
  output logic [CountW-1:0]      lit_seconds_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned TickW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int unsigned CmpW  = (SAMPLE_BITS > SetpointW) ? SAMPLE_BITS : SetpointW;
  localparam logic [TickW-1:0] TickLast = TickW'(TICKS_PER_SECOND - 1);

  // configuration registers
  setpoint_t moist_sp_q, temp_sp_q, light_thr_q;
  logic      photo_en_q;
  count_t    goal_q;

  // input register
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_light_q, s1_temp_q, s1_moist_q;
  logic                   s1_clear_q;

  // control state
  logic [AVERAGE_SHIFT-1:0] slot_q;
  logic [TickW-1:0]         tick_q, tick_d;
  count_t                   lit_q, lit_d;
  logic                     grow_q;

  // result register
  logic                   out_valid_q;
  logic [MeanW-1:0]       lm_out_q, tm_out_q, mm_out_q;
  drive_t                 drive_q, drive_d;

  logic                   adv;
  logic                   tick_wrap;
  logic [SAMPLE_BITS-1:0] lm, tm, mm;
  logic                   daylight;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moist_sp_q  <= MoistureSetpointRst;
      temp_sp_q   <= TemperatureSetpointRst;
      light_thr_q <= LightThresholdRst;
      photo_en_q  <= PhotoperiodEnableRst;
      goal_q      <= LightGoalSecondsRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MOISTURE_SETPOINT:    moist_sp_q  <= cfg_data_i[SetpointW-1:0];
        REG_TEMPERATURE_SETPOINT: temp_sp_q   <= cfg_data_i[SetpointW-1:0];
        REG_LIGHT_THRESHOLD:      light_thr_q <= cfg_data_i[SetpointW-1:0];
        REG_PHOTOPERIOD_ENABLE:   photo_en_q  <= cfg_data_i[0];
        REG_LIGHT_GOAL_SECONDS:   goal_q      <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_light_q <= light_sample_i;
      s1_temp_q  <= temperature_sample_i;
      s1_moist_q <= moisture_sample_i;
      s1_clear_q <= clear_light_count_i;
    end
  end

  // --------------------------------------------------------------------------
  // Filters
  // --------------------------------------------------------------------------
  sat_channel #(
    .AVERAGE_SHIFT(AVERAGE_SHIFT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_light (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(adv),
    .slot_i  (slot_q),
    .sample_i(s1_light_q),
    .mean_o  (lm)
  );

  sat_channel #(
    .AVERAGE_SHIFT(AVERAGE_SHIFT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(adv),
    .slot_i  (slot_q),
    .sample_i(s1_temp_q),
    .mean_o  (tm)
  );

  sat_channel #(
    .AVERAGE_SHIFT(AVERAGE_SHIFT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_moist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(adv),
    .slot_i  (slot_q),
    .sample_i(s1_moist_q),
    .mean_o  (mm)
  );

  // --------------------------------------------------------------------------
  // Lit-seconds counter and drive bits
  // --------------------------------------------------------------------------
  assign tick_wrap = (tick_q == TickLast);
  assign tick_d    = tick_wrap ? '0 : tick_q + TickW'(1);
  assign daylight  = CmpW'(lm) <= CmpW'(light_thr_q);

  always_comb begin
    lit_d = lit_q;
    if (s1_clear_q) begin
      lit_d = '0;
    end else if (tick_wrap && (grow_q || daylight) && (lit_q != '1)) begin
      lit_d = lit_q + count_t'(1);
    end
  end

  always_comb begin
    drive_d.pump = CmpW'(mm) > CmpW'(moist_sp_q);
    drive_d.fan  = CmpW'(tm) < CmpW'(temp_sp_q);
    drive_d.grow = photo_en_q && (lit_d < goal_q) && !daylight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      tick_q <= '0;
      lit_q  <= '0;
      grow_q <= 1'b0;
    end else if (adv) begin
      slot_q <= slot_q + AVERAGE_SHIFT'(1);
      tick_q <= tick_d;
      lit_q  <= lit_d;
      grow_q <= drive_d.grow;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lm_out_q <= MeanW'(lm);
      tm_out_q <= MeanW'(tm);
      mm_out_q <= MeanW'(mm);
      drive_q  <= drive_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign light_mean_o       = lm_out_q;
  assign temperature_mean_o = tm_out_q;
  assign moisture_mean_o    = mm_out_q;
  assign pump_on_o          = drive_q.pump;
  assign fan_on_o           = drive_q.fan;
  assign grow_light_on_o    = drive_q.grow;
  assign lit_seconds_o      = lit_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SAT_ASSERT_ALWAYS(a_tick_range, tick_q <= TickLast, "tick counter out of range")
  `SAT_ASSERT_NEXT(a_clear_zeroes, adv && s1_clear_q, lit_seconds_o == '0, "clear missed")
  `SAT_ASSERT_NEXT(a_count_monotonic, adv && !s1_clear_q, lit_q >= $past(lit_q), "count fell")
  `SAT_ASSERT_NEXT(a_result_follows, adv, out_valid_q, "processed item produced no result")

endmodule

### tb/sv/sensor_average_threshold_control_test.sv
// ----------------------------------------------------------------------------
// sensor_average_threshold_control_test
// Drives sample ticks through the sensor averaging block and checks every
// readout against a local model of the running means, the lit-seconds counter
// and the drive bits. Runs a directed opening and several register settings
// with random traffic. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module sensor_average_threshold_control_test;
  import sat_pkg::*;

  localparam int unsigned SampleW        = 12;
  localparam int unsigned AvgShift       = 5;
  localparam int unsigned HistDepth      = 1 << AvgShift;
  localparam int unsigned TicksPerSecond = 10;
  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned HoldCycles     = 120;
  localparam int unsigned TicksPerPhase  = 290;
  localparam int unsigned NumPhases      = 6;

  typedef struct packed {
    logic [SampleW-1:0] light;
    logic [SampleW-1:0] temperature;
    logic [SampleW-1:0] moisture;
    logic               clear;
  } tick_t;

  typedef struct packed {
    logic [MeanW-1:0] light_mean;
    logic [MeanW-1:0] temperature_mean;
    logic [MeanW-1:0] moisture_mean;
    logic             pump_on;
    logic             fan_on;
    logic             grow_light_on;
    count_t           lit_seconds;
  } readout_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_EVERY_THIRD,
    READY_MOSTLY
  } stall_mode_e;

  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b0;
  logic                in_valid_i           = 1'b0;
  logic                in_ready_o;
  logic [SampleW-1:0]  light_sample_i       = '0;
  logic [SampleW-1:0]  temperature_sample_i = '0;
  logic [SampleW-1:0]  moisture_sample_i    = '0;
  logic                clear_light_count_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i          = 1'b0;
  logic [MeanW-1:0]    light_mean_o;
  logic [MeanW-1:0]    temperature_mean_o;
  logic [MeanW-1:0]    moisture_mean_o;
  logic                pump_on_o;
  logic                fan_on_o;
  logic                grow_light_on_o;
  logic [CountW-1:0]   lit_seconds_o;
  logic                cfg_valid_i          = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i          = '0;
  logic [CfgDataW-1:0] cfg_data_i           = '0;

  sensor_average_threshold_control dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .light_sample_i       (light_sample_i),
    .temperature_sample_i (temperature_sample_i),
    .moisture_sample_i    (moisture_sample_i),
    .clear_light_count_i  (clear_light_count_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .light_mean_o         (light_mean_o),
    .temperature_mean_o   (temperature_mean_o),
    .moisture_mean_o      (moisture_mean_o),
    .pump_on_o            (pump_on_o),
    .fan_on_o             (fan_on_o),
    .grow_light_on_o      (grow_light_on_o),
    .lit_seconds_o        (lit_seconds_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model of the filter state and registers
  logic [SampleW-1:0] history [3][HistDepth];
  logic [16:0]        chan_sum [3];
  logic [AvgShift-1:0] slot;
  int unsigned        tick_phase;
  count_t             lit_count;
  logic               grow_was_on;

  setpoint_t moist_sp    = MoistureSetpointRst;
  setpoint_t temp_sp     = TemperatureSetpointRst;
  setpoint_t light_thr   = LightThresholdRst;
  logic      photo_en    = PhotoperiodEnableRst;
  count_t    light_goal  = LightGoalSecondsRst;

  tick_t    tick_queue[$];
  readout_t expected_readouts[$];
  int       errors = 0;

  function automatic readout_t filter_tick(input tick_t t);
    logic [SampleW-1:0] s [3];
    logic [MeanW-1:0]   avg [3];
    readout_t           r;
    s[0] = t.light;
    s[1] = t.temperature;
    s[2] = t.moisture;
    for (int c = 0; c < 3; c++) begin
      chan_sum[c] = chan_sum[c] - history[c][slot] + s[c];
      history[c][slot] = s[c];
      avg[c] = MeanW'(chan_sum[c] >> AvgShift);
    end
    slot = slot + 1'b1;
    tick_phase++;
    if (tick_phase >= TicksPerSecond) begin
      tick_phase = 0;
      // light state from the previous tick, mean from this one
      if (!t.clear && (grow_was_on || avg[0] <= light_thr) && lit_count != '1) begin
        lit_count = lit_count + 1'b1;
      end
    end
    if (t.clear) begin
      lit_count = '0;
    end
    r.light_mean       = avg[0];
    r.temperature_mean = avg[1];
    r.moisture_mean    = avg[2];
    r.pump_on          = avg[2] > moist_sp;
    r.fan_on           = avg[1] < temp_sp;
    r.grow_light_on    = photo_en && (lit_count < light_goal) && (avg[0] > light_thr);
    r.lit_seconds      = lit_count;
    grow_was_on        = r.grow_light_on;
    return r;
  endfunction

  function automatic logic [SampleW-1:0] clamp_sample(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > 4095) begin
      return '1;
    end
    return SampleW'(v);
  endfunction

  function automatic tick_t make_tick(input int l, input int t, input int m, input bit c);
    tick_t k;
    k.light       = clamp_sample(l);
    k.temperature = clamp_sample(t);
    k.moisture    = clamp_sample(m);
    k.clear       = c;
    return k;
  endfunction

  // Sender: bursts of random length separated by random gaps
  tick_t cur_tick;
  int    burst_left = 1;
  int    gap_left   = 0;
  bit    took;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        expected_readouts.push_back(filter_tick(cur_tick));
      end
      if (!in_valid_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          cur_tick = tick_queue.pop_front();
          light_sample_i       <= cur_tick.light;
          temperature_sample_i <= cur_tick.temperature;
          moisture_sample_i    <= cur_tick.moisture;
          clear_light_count_i  <= cur_tick.clear;
          in_valid_i           <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes mode now and then; two long holds
  stall_mode_e stall_mode  = READY_ALWAYS;
  int          mode_left   = 0;
  int          hold_left   = 0;
  int unsigned pattern_ctr = 0;
  int unsigned readouts_seen = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_readout();
    readout_t want;
    if (expected_readouts.size() == 0) begin
      $error("readout with none expected: light_mean %0d lit_seconds %0d",
             light_mean_o, lit_seconds_o);
      errors++;
      return;
    end
    want = expected_readouts.pop_front();
    check_field("light_mean", want.light_mean, light_mean_o);
    check_field("temperature_mean", want.temperature_mean, temperature_mean_o);
    check_field("moisture_mean", want.moisture_mean, moisture_mean_o);
    check_field("pump_on", want.pump_on, pump_on_o);
    check_field("fan_on", want.fan_on, fan_on_o);
    check_field("grow_light_on", want.grow_light_on, grow_light_on_o);
    check_field("lit_seconds", want.lit_seconds, lit_seconds_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_readout();
        readouts_seen++;
        // long hold-offs so the block fills and backs up its input
        if (readouts_seen == 300 || readouts_seen == 1100) begin
          hold_left = HoldCycles;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(30, 200);
        end else begin
          mode_left--;
        end
        pattern_ctr++;
        case (stall_mode)
          READY_ALWAYS:      out_ready_i <= 1'b1;
          READY_COIN:        out_ready_i <= 1'($urandom_range(0, 1));
          READY_EVERY_THIRD: out_ready_i <= (pattern_ctr % 3 == 0);
          default:           out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("sensor_average_threshold_control_test: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MOISTURE_SETPOINT:    moist_sp   = value[SetpointW-1:0];
      REG_TEMPERATURE_SETPOINT: temp_sp    = value[SetpointW-1:0];
      REG_LIGHT_THRESHOLD:      light_thr  = value[SetpointW-1:0];
      REG_PHOTOPERIOD_ENABLE:   photo_en   = value[0];
      REG_LIGHT_GOAL_SECONDS:   light_goal = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid_i || expected_readouts.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Runs of similar samples near the setpoints so means cross them,
  // mixed with fully random ticks
  task automatic queue_random_ticks(input int count);
    int    run_left;
    int    level [3];
    int    center [3];
    tick_t t;
    run_left  = 0;
    center[0] = int'(light_thr);
    center[1] = int'(temp_sp);
    center[2] = int'(moist_sp);
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 80);
        for (int c = 0; c < 3; c++) begin
          level[c] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095))
                                                 : center[c] + int'($urandom_range(0, 600)) - 300;
        end
      end
      run_left--;
      if ($urandom_range(0, 7) == 0) begin
        t.light       = SampleW'($urandom);
        t.temperature = SampleW'($urandom);
        t.moisture    = SampleW'($urandom);
      end else begin
        t.light       = clamp_sample(level[0] + int'($urandom_range(0, 128)) - 64);
        t.temperature = clamp_sample(level[1] + int'($urandom_range(0, 128)) - 64);
        t.moisture    = clamp_sample(level[2] + int'($urandom_range(0, 128)) - 64);
      end
      t.clear = ($urandom_range(0, 79) == 0);
      tick_queue.push_back(t);
    end
  endtask

  initial begin
    int l;
    for (int c = 0; c < 3; c++) begin
      chan_sum[c] = '0;
      for (int i = 0; i < HistDepth; i++) begin
        history[c][i] = '0;
      end
    end
    slot        = '0;
    tick_phase  = 0;
    lit_count   = '0;
    grow_was_on = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening at reset register values: warm-up from zero, full
    // scale, bit patterns, values at the setpoints, clears on and off the
    // counting tick
    for (int i = 0; i < 24; i++) begin
      if (i < 2) begin
        l = 0;
      end else if (i < 10) begin
        l = 4095;
      end else if (i < 12) begin
        l = (i % 2 == 0) ? 'hAAA : 'h555;
      end else if (i < 19) begin
        l = -1;
      end else begin
        l = 4095;
      end
      if (l < 0) begin
        tick_queue.push_back(make_tick(2000, 1600, 3000, i == 19));
      end else begin
        tick_queue.push_back(make_tick(l, l, l, i == 4 || i == 9 || i == 19));
      end
    end
    wait_drained();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MOISTURE_SETPOINT, 32'd2048);
          write_reg(REG_TEMPERATURE_SETPOINT, 32'd2048);
          write_reg(REG_LIGHT_THRESHOLD, 32'd2000);
          write_reg(REG_PHOTOPERIOD_ENABLE, 32'd1);
          write_reg(REG_LIGHT_GOAL_SECONDS, 32'd30);
        end
        1: begin
          write_reg(REG_MOISTURE_SETPOINT, 32'd0);
          write_reg(REG_TEMPERATURE_SETPOINT, 32'd0);
          write_reg(REG_LIGHT_THRESHOLD, 32'd0);
          write_reg(REG_LIGHT_GOAL_SECONDS, 32'd0);
        end
        2: begin
          // upper bits beyond each register width are dropped
          write_reg(REG_MOISTURE_SETPOINT, 32'hFFFF_FFFF);
          write_reg(REG_TEMPERATURE_SETPOINT, 32'hFFFF_FFFF);
          write_reg(REG_LIGHT_THRESHOLD, 32'hFFFF_FFFF);
          write_reg(REG_PHOTOPERIOD_ENABLE, 32'hFFFF_FFFF);
          write_reg(REG_LIGHT_GOAL_SECONDS, 32'hFFFF_FFFF);
        end
        3, 4: begin
          write_reg(REG_MOISTURE_SETPOINT, $urandom);
          write_reg(REG_TEMPERATURE_SETPOINT, $urandom);
          write_reg(REG_LIGHT_THRESHOLD, $urandom);
          write_reg(REG_PHOTOPERIOD_ENABLE, (phase == 3) ? $urandom : 32'd1);
          write_reg(REG_LIGHT_GOAL_SECONDS, $urandom_range(3, 60));
        end
        default: begin
          write_reg(REG_MOISTURE_SETPOINT, $urandom);
          write_reg(REG_TEMPERATURE_SETPOINT, $urandom);
          write_reg(REG_LIGHT_THRESHOLD, $urandom);
          write_reg(REG_PHOTOPERIOD_ENABLE, 32'hFFFF_FFFE);
          write_reg(REG_LIGHT_GOAL_SECONDS, $urandom);
        end
      endcase
      @(negedge clk_i);
      queue_random_ticks(TicksPerPhase);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("sensor_average_threshold_control_test: done, clean");
    end else begin
      $display("sensor_average_threshold_control_test: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/sat_pkg.sv
hw/rtl/sat_channel.sv
hw/rtl/sensor_average_threshold_control.sv
tb/sv/sensor_average_threshold_control_test.sv
